// File: src/bsfd_pkg.sv
package bsfd_pkg;

   // configuration port geometry
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_FIRST  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_SECOND = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_THIRD  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEAD_FOURTH = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TAIL_MARKER = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LENGTH  = 3'd5;

   localparam logic [15:0] MAX_LENGTH_RESET = 16'd1024;

   typedef enum logic [1:0] {
      KIND_BODY     = 2'd0,
      KIND_GOOD     = 2'd1,
      KIND_BAD_TAIL = 2'd2,
      KIND_REJECT   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]  head_first;
      logic [7:0]  head_second;
      logic [7:0]  head_third;
      logic [7:0]  head_fourth;
      logic [7:0]  tail_marker;
      logic [15:0] max_length;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [15:0] frame_len;
   } rsp_type;

endpackage

// File: src/bsfd_csr.sv
module bsfd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [bsfd_pkg::CSR_INDEX_W-1:0] index,
   input  logic [bsfd_pkg::CSR_DATA_W-1:0]  wr_data,
   output bsfd_pkg::cfg_type                cfg
);

   bsfd_pkg::cfg_type cfg_ff;
   bsfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            bsfd_pkg::CSR_HEAD_FIRST:  cfg_in.head_first  = wr_data[7:0];
            bsfd_pkg::CSR_HEAD_SECOND: cfg_in.head_second = wr_data[7:0];
            bsfd_pkg::CSR_HEAD_THIRD:  cfg_in.head_third  = wr_data[7:0];
            bsfd_pkg::CSR_HEAD_FOURTH: cfg_in.head_fourth = wr_data[7:0];
            bsfd_pkg::CSR_TAIL_MARKER: cfg_in.tail_marker = wr_data[7:0];
            bsfd_pkg::CSR_MAX_LENGTH:  cfg_in.max_length  = wr_data[15:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_first  <= 8'h00;
         cfg_ff.head_second <= 8'h00;
         cfg_ff.head_third  <= 8'h00;
         cfg_ff.head_fourth <= 8'h00;
         cfg_ff.tail_marker <= 8'h00;
         cfg_ff.max_length  <= bsfd_pkg::MAX_LENGTH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/bsfd_parser.sv
module bsfd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  bsfd_pkg::cfg_type  cfg,
   output logic               res_valid,
   output bsfd_pkg::rsp_type  res
);

   typedef enum logic [2:0] {
      PH_HUNT = 3'b001,
      PH_LEN  = 3'b010,
      PH_BODY = 3'b100
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [23:0] seen_ff, seen_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;

   logic [15:0] count_inc;
   logic [15:0] len_full;
   logic        head_match;

   assign count_inc  = count_ff + 16'd1;
   assign len_full   = {in_byte, length_ff[7:0]};
   assign head_match = (seen_ff[23:16] == cfg.head_first) &&
                       (seen_ff[15:8]  == cfg.head_second) &&
                       (seen_ff[7:0]   == cfg.head_third) &&
                       (in_byte        == cfg.head_fourth);

   always_comb begin
      phase_in  = phase_ff;
      seen_in   = seen_ff;
      count_in  = count_ff;
      length_in = length_ff;
      res_valid = 1'b0;
      res.kind      = bsfd_pkg::KIND_BODY;
      res.out_byte  = in_byte;
      res.frame_len = length_ff;
      if (in_valid) begin
         case (phase_ff)
            PH_LEN: begin
               if (count_ff == 16'd0) begin
                  length_in = {8'h00, in_byte};
                  count_in  = 16'd1;
               end else begin
                  length_in = len_full;
                  count_in  = 16'd0;
                  if ((len_full == 16'd0) || (len_full > cfg.max_length)) begin
                     // bad length: report and go back to hunting
                     phase_in      = PH_HUNT;
                     seen_in       = 24'h000000;
                     res_valid     = 1'b1;
                     res.kind      = bsfd_pkg::KIND_REJECT;
                     res.out_byte  = 8'h00;
                     res.frame_len = len_full;
                  end else begin
                     phase_in = PH_BODY;
                  end
               end
            end
            PH_BODY: begin
               res_valid = 1'b1;
               if (count_inc < length_ff) begin
                  count_in = count_inc;
               end else begin
                  // last byte closes the frame
                  phase_in = PH_HUNT;
                  seen_in  = 24'h000000;
                  count_in = 16'd0;
                  res.kind = (in_byte == cfg.tail_marker) ? bsfd_pkg::KIND_GOOD
                                                          : bsfd_pkg::KIND_BAD_TAIL;
               end
            end
            default: begin
               // header hunt, whole groups of four
               phase_in = PH_HUNT;
               if (count_ff < 16'd3) begin
                  seen_in  = {seen_ff[15:0], in_byte};
                  count_in = count_inc;
               end else begin
                  seen_in  = 24'h000000;
                  count_in = 16'd0;
                  if (head_match) begin
                     phase_in  = PH_LEN;
                     length_in = 16'd0;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         seen_ff   <= 24'h000000;
         count_ff  <= 16'd0;
         length_ff <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         seen_ff   <= seen_in;
         count_ff  <= count_in;
         length_ff <= length_in;
      end
   end

   a_hunt_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT) |-> (count_ff <= 16'd3))
      else $error("hunt group counter past four bytes");

   a_body_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_BODY) |-> (count_ff < length_ff))
      else $error("body counter reached frame length");

endmodule

// File: src/bsfd_out_buf.sv
module bsfd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bsfd_pkg::rsp_type push_data,
   output logic              space,
   output logic              out_valid,
   input  logic              out_ready,
   output bsfd_pkg::rsp_type out_data
);

   logic              main_valid_ff, main_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   bsfd_pkg::rsp_type main_ff, main_in;
   bsfd_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop = main_valid_ff && out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign space     = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid entry held with empty output register");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !skid_valid_ff)
      else $error("result pushed while skid entry occupied");

   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && pop) |=> (main_valid_ff && (main_ff == $past(skid_ff))))
      else $error("skid entry lost on output transfer");

endmodule

// File: src/byte_stream_frame_deframer.sv
// Byte stream frame deframer.
//
// req_ channel: one received byte per transfer (req_rx_byte). The block looks for
// a four-byte header in aligned groups of four, then a little-endian 16-bit
// length, then passes the body through. rsp_ channel: one result per body byte,
// a frame end (good / bad tail) on the last body byte, or a length reject.
// Header bytes and accepted length bytes give no result.
// csr_ port: plain write port, no read-back; write only while idle.
//
// Throughput: one byte per cycle, sustained while req_ready is high. The parse is
// a single combinational pass from the accepted byte and the state registers
// into the result register, or into the skid entry while the receiver stalls.
// A two-entry output buffer (result register plus skid) decouples the sides:
// req_ready is low only while both entries are full, i.e. after a new result
// came in while the receiver stalled with a result waiting.
// Reset (synchronous, active high) returns the parser to the header hunt,
// empties the output buffer and loads the register defaults (headers and tail
// zero, max length 1024).
module byte_stream_frame_deframer (
   input  logic                             clock,
   input  logic                             reset,
   // input bytes
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_rx_byte,
   // results
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_kind,
   output logic [7:0]                       rsp_out_byte,
   output logic [15:0]                      rsp_frame_len,
   // configuration
   input  logic                             csr_wr_en,
   input  logic [bsfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [bsfd_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   bsfd_pkg::cfg_type cfg;
   bsfd_pkg::rsp_type res;
   bsfd_pkg::rsp_type rsp_data;
   logic              res_valid;
   logic              space;
   logic              req_xfer;

   // a byte is taken whenever the skid entry is free
   assign req_ready = space;
   assign req_xfer  = req_valid && space;

   bsfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_wr_en),
      .index   (csr_index),
      .wr_data (csr_wr_data),
      .cfg     (cfg)
   );

   // hunt / length / body state machine, updated on each input transfer
   bsfd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_xfer),
      .in_byte   (req_rx_byte),
      .cfg       (cfg),
      .res_valid (res_valid),
      .res       (res)
   );

   // result register and skid entry
   bsfd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_kind      = rsp_data.kind;
   assign rsp_out_byte  = rsp_data.out_byte;
   assign rsp_frame_len = rsp_data.frame_len;

endmodule
